// ===== hw/rtl/fcr_pkg.sv =====
// Shared types and constants of the FAT32 cluster chain reader.
package fcr_pkg;

    localparam int unsigned SECTOR_BYTES = 512;
    localparam int unsigned CLUSTER_W = 28;
    localparam int unsigned ADDR_W = 32;
    localparam int unsigned COUNT_W = 10;
    localparam int unsigned OFFSET_W = 9;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CLUSTER_W-1:0] END_MARK = 28'hFFFFFF8;
    localparam logic [ADDR_W-1:0] FIRST_DATA_CLUSTER = 32'd2;
    localparam logic [COUNT_W-1:0] SECTOR_COUNT = 10'(SECTOR_BYTES);

    typedef enum logic {
        OP_START = 1'b0,
        OP_REPLY = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_FAT  = 2'd1,
        KIND_DONE = 2'd2
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RESERVED_COUNT   = 2'd0,
        CFG_FAT_COPIES       = 2'd1,
        CFG_FAT_LENGTH       = 2'd2,
        CFG_CLUSTER_SECTORS  = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [15:0]       reserved_count;
        logic [7:0]        cluster_sectors;
        logic [ADDR_W-1:0] fat_area;
    } geom_t;

    typedef struct packed {
        op_t                  op;
        logic [CLUSTER_W-1:0] cluster;
        logic [ADDR_W-1:0]    file_bytes;
        logic [ADDR_W-1:0]    cluster_offset;
    } item_t;

    typedef struct packed {
        kind_t               kind;
        logic [ADDR_W-1:0]   lba;
        logic [COUNT_W-1:0]  byte_count;
        logic [OFFSET_W-1:0] entry_offset;
        logic                last;
    } result_t;

endpackage

// ===== hw/rtl/fat32_cluster_chain_reader.sv =====
// Top level of the FAT32 cluster chain reader.
// A start transfer loads a file's first cluster and size; each FAT reply transfer supplies
// the next cluster. For every cluster that still holds file bytes the block emits a data
// sector read (first sector of the cluster only) followed by a FAT sector read marked last,
// and when the chain or the file ends it emits a single finished result. Replies that arrive
// while no walk is in progress produce nothing. The block accepts one input transfer per
// cycle while its input stages have room; an item that produces a read pair occupies the
// single result port for both of its reads, and the walk stage takes the next item only
// once that pair's FAT read is being taken. Geometry registers reset to 32 reserved
// sectors, 2 FAT copies, a FAT length of 0 and 8 sectors per cluster, and may be written
// only while the block is idle.
module fat32_cluster_chain_reader (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [fcr_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [fcr_pkg::ADDR_W-1:0]     cfg_wr_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_operation,
    input  logic [fcr_pkg::CLUSTER_W-1:0]  s_start_cluster,
    input  logic [fcr_pkg::ADDR_W-1:0]     s_file_bytes,
    input  logic [fcr_pkg::ADDR_W-1:0]     s_fat_word,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [1:0]                     m_request_kind,
    output logic [fcr_pkg::ADDR_W-1:0]     m_sector_lba,
    output logic [fcr_pkg::COUNT_W-1:0]    m_byte_count,
    output logic [fcr_pkg::OFFSET_W-1:0]   m_entry_offset,
    output logic                           m_last
);

    fcr_pkg::geom_t   geom;
    fcr_pkg::item_t   item;
    fcr_pkg::result_t result;
    logic             item_valid;
    logic             item_ready;

    fcr_cfg u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .geom        (geom)
    );

    fcr_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_start_cluster (s_start_cluster),
        .s_file_bytes    (s_file_bytes),
        .s_fat_word      (s_fat_word),
        .cluster_sectors (geom.cluster_sectors),
        .item_valid      (item_valid),
        .item_ready      (item_ready),
        .item            (item)
    );

    fcr_walk u_walk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .geom       (geom),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_result   (result)
    );

    assign m_request_kind = result.kind;
    assign m_sector_lba   = result.lba;
    assign m_byte_count   = result.byte_count;
    assign m_entry_offset = result.entry_offset;
    assign m_last         = result.last;

    // A data read transfer is always followed directly by its FAT read.
    a_data_then_fat: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_request_kind == fcr_pkg::KIND_DATA)
        |=> (m_valid && m_request_kind == fcr_pkg::KIND_FAT))
        else $error("Data read was not followed by its FAT read.");

    // A data read is never last and carries between one and a full sector of bytes.
    a_data_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_request_kind == fcr_pkg::KIND_DATA)
        |-> (!m_last && m_byte_count != '0 && m_byte_count <= fcr_pkg::SECTOR_COUNT))
        else $error("Data read has a bad byte count or last flag.");

    // FAT reads and finished results close the output of their item.
    a_last_kinds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_request_kind == fcr_pkg::KIND_FAT ||
                     m_request_kind == fcr_pkg::KIND_DONE))
        |-> m_last)
        else $error("FAT read or finished result is not marked last.");

endmodule

// ===== hw/rtl/fcr_cfg.sv =====
// Volume geometry registers and the registered size of the FAT area.
module fcr_cfg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [fcr_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [fcr_pkg::ADDR_W-1:0]     cfg_wr_data,
    output fcr_pkg::geom_t                 geom
);

    logic [15:0]                reserved_reg;
    logic [7:0]                 copies_reg;
    logic [fcr_pkg::ADDR_W-1:0] fat_length_reg;
    logic [7:0]                 cluster_sectors_reg;
    logic [fcr_pkg::ADDR_W-1:0] fat_area_reg;
    logic [fcr_pkg::ADDR_W-1:0] fat_area_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reserved_reg        <= 16'd32;
            copies_reg          <= 8'd2;
            fat_length_reg      <= '0;
            cluster_sectors_reg <= 8'd8;
        end else if (cfg_wr_en) begin
            unique case (fcr_pkg::cfg_idx_t'(cfg_addr))
                fcr_pkg::CFG_RESERVED_COUNT:   reserved_reg <= cfg_wr_data[15:0];
                fcr_pkg::CFG_FAT_COPIES:       copies_reg <= cfg_wr_data[7:0];
                fcr_pkg::CFG_FAT_LENGTH:       fat_length_reg <= cfg_wr_data;
                fcr_pkg::CFG_CLUSTER_SECTORS:  cluster_sectors_reg <= cfg_wr_data[7:0];
            endcase
        end
    end

    assign fat_area_next = {24'd0, copies_reg} * fat_length_reg;

    always_ff @(posedge aclk) begin
        fat_area_reg <= fat_area_next;
    end

    assign geom.reserved_count   = reserved_reg;
    assign geom.cluster_sectors  = cluster_sectors_reg;
    assign geom.fat_area         = fat_area_reg;

endmodule

// ===== hw/rtl/fcr_front.sv =====
// Input register and cluster offset product stage of the chain reader.
module fcr_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_operation,
    input  logic [fcr_pkg::CLUSTER_W-1:0]  s_start_cluster,
    input  logic [fcr_pkg::ADDR_W-1:0]     s_file_bytes,
    input  logic [fcr_pkg::ADDR_W-1:0]     s_fat_word,
    input  logic [7:0]                     cluster_sectors,
    output logic                           item_valid,
    input  logic                           item_ready,
    output fcr_pkg::item_t                 item
);

    logic                           s1_valid_reg;
    fcr_pkg::op_t                   s1_op_reg;
    logic [fcr_pkg::CLUSTER_W-1:0]  s1_cluster_reg;
    logic [fcr_pkg::ADDR_W-1:0]     s1_bytes_reg;
    logic                           s2_valid_reg;
    fcr_pkg::item_t                 s2_item_reg;
    fcr_pkg::item_t                 s2_item_next;
    logic [fcr_pkg::ADDR_W-1:0]     rel_cluster;
    logic                           adv1;
    logic                           adv2;

    assign adv2    = !s2_valid_reg || item_ready;
    assign adv1    = !s1_valid_reg || adv2;
    assign s_ready = adv1;

    // Clusters are numbered from two, so the data offset uses the relative cluster.
    assign rel_cluster = {4'd0, s1_cluster_reg} - fcr_pkg::FIRST_DATA_CLUSTER;

    always_comb begin
        s2_item_next.op             = s1_op_reg;
        s2_item_next.cluster        = s1_cluster_reg;
        s2_item_next.file_bytes     = s1_bytes_reg;
        s2_item_next.cluster_offset = rel_cluster * {24'd0, cluster_sectors};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            if (adv1) begin
                s1_valid_reg <= s_valid;
            end
            if (adv2) begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv1 && s_valid) begin
            s1_op_reg      <= fcr_pkg::op_t'(s_operation);
            s1_cluster_reg <= (fcr_pkg::op_t'(s_operation) == fcr_pkg::OP_START) ?
                              s_start_cluster : s_fat_word[fcr_pkg::CLUSTER_W-1:0];
            s1_bytes_reg   <= s_file_bytes;
        end
        if (adv2 && s1_valid_reg) begin
            s2_item_reg <= s2_item_next;
        end
    end

    assign item_valid = s2_valid_reg;
    assign item       = s2_item_reg;

endmodule

// ===== hw/rtl/fcr_walk.sv =====
// Chain walk state, request generation and the two-entry result buffer.
module fcr_walk (
    input  logic              aclk,
    input  logic              aresetn,
    input  fcr_pkg::geom_t    geom,
    input  logic              item_valid,
    output logic              item_ready,
    input  fcr_pkg::item_t    item,
    output logic              m_valid,
    input  logic              m_ready,
    output fcr_pkg::result_t  m_result
);

    logic [fcr_pkg::ADDR_W-1:0]  remaining_reg;
    logic [fcr_pkg::ADDR_W-1:0]  remaining_next;
    logic                        awaiting_reg;
    logic                        awaiting_next;
    logic                        cur_valid_reg;
    logic                        sec_valid_reg;
    fcr_pkg::result_t            cur_reg;
    fcr_pkg::result_t            sec_reg;
    fcr_pkg::result_t            res0;
    fcr_pkg::result_t            res1;
    logic [fcr_pkg::ADDR_W-1:0]  rem_sel;
    logic [fcr_pkg::COUNT_W-1:0] count;
    logic                        ignore;
    logic                        go;
    logic                        out_free;
    logic                        fire;

    assign out_free   = !cur_valid_reg || (m_ready && !sec_valid_reg);
    assign item_ready = out_free;
    assign fire       = item_valid && out_free;

    always_comb begin
        ignore  = (item.op == fcr_pkg::OP_REPLY) && !awaiting_reg;
        rem_sel = (item.op == fcr_pkg::OP_START) ? item.file_bytes : remaining_reg;
        go      = (rem_sel != '0) && (item.cluster < fcr_pkg::END_MARK);
        count   = (rem_sel > {22'd0, fcr_pkg::SECTOR_COUNT}) ?
                  fcr_pkg::SECTOR_COUNT : rem_sel[fcr_pkg::COUNT_W-1:0];

        remaining_next = go ? (rem_sel - {22'd0, count}) : rem_sel;
        awaiting_next  = go;

        res1.kind         = fcr_pkg::KIND_FAT;
        res1.lba          = {16'd0, geom.reserved_count} + {11'd0, item.cluster[27:7]};
        res1.byte_count   = '0;
        res1.entry_offset = {item.cluster[6:0], 2'b00};
        res1.last         = 1'b1;

        if (go) begin
            res0.kind         = fcr_pkg::KIND_DATA;
            res0.lba          = {16'd0, geom.reserved_count} + geom.fat_area +
                                item.cluster_offset;
            res0.byte_count   = count;
            res0.entry_offset = '0;
            res0.last         = 1'b0;
        end else begin
            res0.kind         = fcr_pkg::KIND_DONE;
            res0.lba          = '0;
            res0.byte_count   = '0;
            res0.entry_offset = '0;
            res0.last         = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            remaining_reg <= '0;
            awaiting_reg  <= 1'b0;
            cur_valid_reg <= 1'b0;
            sec_valid_reg <= 1'b0;
        end else begin
            if (fire && !ignore) begin
                remaining_reg <= remaining_next;
                awaiting_reg  <= awaiting_next;
                cur_valid_reg <= 1'b1;
                sec_valid_reg <= go;
            end else if (cur_valid_reg && m_ready) begin
                cur_valid_reg <= sec_valid_reg;
                sec_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && !ignore) begin
            cur_reg <= res0;
            sec_reg <= res1;
        end else if (cur_valid_reg && m_ready) begin
            cur_reg <= sec_reg;
        end
    end

    assign m_valid  = cur_valid_reg;
    assign m_result = cur_reg;

endmodule
